// ----- hdl/aot_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aot_pkg
// Shared constants, angle table and sequencer state codes for the arc
// outline tessellator.
// ----------------------------------------------------------------------------
package aot_pkg;

  localparam int CORDIC_ITERATIONS = 20;
  localparam int ITER_CW = (CORDIC_ITERATIONS > 1) ? $clog2(CORDIC_ITERATIONS) : 1;

  // datapath widths
  localparam int CW  = 40;   // cordic x / y
  localparam int AW  = 38;   // angles, q8.30 radians
  localparam int VW  = 33;   // centre-relative vectors
  localparam int MW  = 34;   // multiplier operands
  localparam int SW  = 7;    // step count
  localparam int DCW = 6;    // divider bit counter

  localparam logic signed [AW-1:0] ANG_PI      = 38'sd3373259426;
  localparam logic signed [AW-1:0] ANG_HALF_PI = 38'sd1686629713;
  localparam logic signed [AW-1:0] ANG_TWO_PI  = 38'sd6746518852;
  localparam logic signed [MW-1:0] INV_GAIN    = 34'sd652032874;

  localparam logic [SW-1:0] STEPS_RESET = 7'd16;
  localparam logic [SW-1:0] STEPS_MIN   = 7'd2;
  localparam logic [SW-1:0] STEPS_MAX   = 7'd64;

  localparam logic [1:0] KIND_LINE = 2'd0;
  localparam logic [1:0] KIND_FWD  = 2'd1;
  localparam logic [1:0] KIND_REV  = 2'd2;

  localparam logic [31:0] ATAN_TAB [0:31] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
    32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
    32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
    32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
    32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  typedef enum logic [17:0] {
    S_IDLE    = 18'h00001,
    S_VEC_LD  = 18'h00002,
    S_VEC_IT  = 18'h00004,
    S_SPAN    = 18'h00008,
    S_DIV     = 18'h00010,
    S_ROT_LD  = 18'h00020,
    S_ROT_QT  = 18'h00040,
    S_ROT_IT  = 18'h00080,
    S_MUL_XH  = 18'h00100,
    S_MUL_XL  = 18'h00200,
    S_MUL_YH  = 18'h00400,
    S_MUL_YL  = 18'h00800,
    S_EM_BOX  = 18'h01000,
    S_EM_SQX  = 18'h02000,
    S_EM_SQY  = 18'h04000,
    S_EM_SQRT = 18'h08000,
    S_EM_ACC  = 18'h10000,
    S_EM_OUT  = 18'h20000
  } state_t;

endpackage

// ----- hdl/arc_outline_tessellator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arc_outline_tessellator_unit
// Turns outline control points (line vertices and arc centres) into a
// stream of polyline points with running bounding box and path length.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake           payload
//  in_       input      in_valid/in_stall   point_x, point_y, point_kind, outline_start
//  out_      output     out_valid/out_stall x, y, box, path_length, run_last
//  cfg_      input      cfg_valid/cfg_ready arc_steps (7 bits)
//
//  one item at a time; in_stall is high from the accepting edge until the
//  last result of that item has been loaded into the output register
//  a line vertex with no pending arc: a box update and output, plus a
//  segment length when one is needed (32-step square root)
//  an arc: setup of two vectoring runs and a 38-bit restoring divider,
//  then per interior point up to 3 quarter turns, CORDIC_ITERATIONS
//  rotation steps, high and low partial products for x and y, and the
//  emit steps for box, segment length and output
//  synchronous active-low reset; a stalled output only holds the sequencer
//  in its final emit step, the output register decouples the two sides
// ----------------------------------------------------------------------------
module arc_outline_tessellator_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [31:0]  in_point_x,
  input  logic signed [31:0]  in_point_y,
  input  logic [1:0]          in_point_kind,
  input  logic                in_outline_start,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_x,
  output logic signed [31:0]  out_y,
  output logic signed [31:0]  out_box_min_x,
  output logic signed [31:0]  out_box_min_y,
  output logic signed [31:0]  out_box_max_x,
  output logic signed [31:0]  out_box_max_y,
  output logic [31:0]         out_path_length,
  output logic                out_run_last,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [aot_pkg::SW-1:0] cfg_data
);
  import aot_pkg::*;

  // sequencer
  state_t state_r, state_nxt;

  // configuration
  logic [SW-1:0] arc_steps_r, arc_steps_nxt;

  // outline state
  logic signed [31:0] prev_x_r, prev_x_nxt, prev_y_r, prev_y_nxt;
  logic signed [31:0] cen_x_r, cen_x_nxt, cen_y_r, cen_y_nxt;
  logic [1:0]         pend_kind_r, pend_kind_nxt;
  logic signed [31:0] last_x_r, last_x_nxt, last_y_r, last_y_nxt;
  logic               have_em_r, have_em_nxt;
  logic signed [31:0] bmin_x_r, bmin_x_nxt, bmin_y_r, bmin_y_nxt;
  logic signed [31:0] bmax_x_r, bmax_x_nxt, bmax_y_r, bmax_y_nxt;
  logic               bvalid_r, bvalid_nxt;
  logic [31:0]        len_r, len_nxt;

  // current item
  logic signed [31:0] px_r, px_nxt, py_r, py_nxt;
  logic               item_line_r, item_line_nxt;
  logic               arc_fwd_r, arc_fwd_nxt;
  logic signed [31:0] wcx_r, wcx_nxt, wcy_r, wcy_nxt;
  logic signed [VW-1:0] w1_r, w1_nxt, h1_r, h1_nxt;
  logic [SW-1:0]      steps_r, steps_nxt, k_r, k_nxt;

  // shared cordic unit
  logic signed [CW-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [AW-1:0] cz_r, cz_nxt;
  logic [ITER_CW-1:0]   cnt_r, cnt_nxt;
  logic                 vsel_r, vsel_nxt;
  logic signed [AW-1:0] a1_r, a1_nxt, a2_r, a2_nxt;

  // span divider and angle accumulator
  logic [AW-1:0]  dq_r, dq_nxt;
  logic [SW-1:0]  drem_r, drem_nxt;
  logic [DCW-1:0] dcnt_r, dcnt_nxt;
  logic           span_neg_r, span_neg_nxt;
  logic [AW-1:0]  qs_r, qs_nxt, accq_r, accq_nxt;
  logic [SW-1:0]  rs_r, rs_nxt, accr_r, accr_nxt;

  // shared multiplier
  logic signed [MW-1:0]   mul_a, mul_b;
  logic signed [2*MW-1:0] prod;
  logic signed [55:0]     macc_r, macc_nxt;

  // emit unit
  logic signed [31:0] em_x_r, em_x_nxt, em_y_r, em_y_nxt;
  logic               em_last_r, em_last_nxt, em_line_r, em_line_nxt;
  logic [31:0]        ux_r, ux_nxt, uy_r, uy_nxt;
  logic [63:0]        sq_r, sq_nxt;
  logic [63:0]        sqv_r, sqv_nxt, sqres_r, sqres_nxt, sqone_r, sqone_nxt;
  logic [31:0]        dist_r, dist_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] ox_r, ox_nxt, oy_r, oy_nxt;
  logic signed [31:0] obnx_r, obnx_nxt, obny_r, obny_nxt;
  logic signed [31:0] obxx_r, obxx_nxt, obxy_r, obxy_nxt;
  logic [31:0]        olen_r, olen_nxt;
  logic               olast_r, olast_nxt;

  // combinational helpers
  logic               st;
  logic [1:0]         eff_pk;
  logic signed [31:0] eff_px, eff_py, eff_cx, eff_cy;
  logic signed [VW-1:0] vx, vy;
  logic signed [CW-1:0] sh_x, sh_y;
  logic signed [AW-1:0] atan_v, a2e, span;
  logic [SW:0]        rem_sh, racc;
  logic               qbit, rc;
  logic [AW-1:0]      accq_n;
  logic signed [55:0] tsum;
  logic signed [31:0] sat_v;
  logic signed [32:0] dxe, dye;
  logic [64:0]        sqsum;
  logic [63:0]        sq_trial;
  logic [32:0]        lsum;
  logic               out_free;
  logic               k_last;

  function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
    if (v > 44'sd2147483647) begin
      sat32 = 32'sh7FFFFFFF;
    end else if (v < -44'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;
  assign k_last    = (k_r == steps_r - 7'd1);

  // per-step shifted operands and table entry for the cordic unit
  assign sh_x   = cx_r >>> cnt_r;
  assign sh_y   = cy_r >>> cnt_r;
  assign atan_v = AW'($signed({1'b0, ATAN_TAB[5'(cnt_r)]}));

  // multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = INV_GAIN;
    case (state_r)
      S_MUL_XH: mul_a = MW'($signed(cx_r[CW-1:16]));
      S_MUL_XL: mul_a = MW'({1'b0, cx_r[15:0]});
      S_MUL_YH: mul_a = MW'($signed(cy_r[CW-1:16]));
      S_MUL_YL: mul_a = MW'({1'b0, cy_r[15:0]});
      S_EM_SQX: begin
        mul_a = MW'({1'b0, ux_r});
        mul_b = MW'({1'b0, ux_r});
      end
      S_EM_SQY: begin
        mul_a = MW'({1'b0, uy_r});
        mul_b = MW'({1'b0, uy_r});
      end
      default: mul_a = '0;
    endcase
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    state_nxt     = state_r;
    arc_steps_nxt = arc_steps_r;
    prev_x_nxt    = prev_x_r;
    prev_y_nxt    = prev_y_r;
    cen_x_nxt     = cen_x_r;
    cen_y_nxt     = cen_y_r;
    pend_kind_nxt = pend_kind_r;
    last_x_nxt    = last_x_r;
    last_y_nxt    = last_y_r;
    have_em_nxt   = have_em_r;
    bmin_x_nxt    = bmin_x_r;
    bmin_y_nxt    = bmin_y_r;
    bmax_x_nxt    = bmax_x_r;
    bmax_y_nxt    = bmax_y_r;
    bvalid_nxt    = bvalid_r;
    len_nxt       = len_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    item_line_nxt = item_line_r;
    arc_fwd_nxt   = arc_fwd_r;
    wcx_nxt       = wcx_r;
    wcy_nxt       = wcy_r;
    w1_nxt        = w1_r;
    h1_nxt        = h1_r;
    steps_nxt     = steps_r;
    k_nxt         = k_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    cz_nxt        = cz_r;
    cnt_nxt       = cnt_r;
    vsel_nxt      = vsel_r;
    a1_nxt        = a1_r;
    a2_nxt        = a2_r;
    dq_nxt        = dq_r;
    drem_nxt      = drem_r;
    dcnt_nxt      = dcnt_r;
    span_neg_nxt  = span_neg_r;
    qs_nxt        = qs_r;
    rs_nxt        = rs_r;
    accq_nxt      = accq_r;
    accr_nxt      = accr_r;
    macc_nxt      = macc_r;
    em_x_nxt      = em_x_r;
    em_y_nxt      = em_y_r;
    em_last_nxt   = em_last_r;
    em_line_nxt   = em_line_r;
    ux_nxt        = ux_r;
    uy_nxt        = uy_r;
    sq_nxt        = sq_r;
    sqv_nxt       = sqv_r;
    sqres_nxt     = sqres_r;
    sqone_nxt     = sqone_r;
    dist_nxt      = dist_r;
    out_valid_nxt = out_valid_r && out_stall;
    ox_nxt        = ox_r;
    oy_nxt        = oy_r;
    obnx_nxt      = obnx_r;
    obny_nxt      = obny_r;
    obxx_nxt      = obxx_r;
    obxy_nxt      = obxy_r;
    olen_nxt      = olen_r;
    olast_nxt     = olast_r;

    st     = in_outline_start;
    eff_pk = st ? KIND_LINE : pend_kind_r;
    eff_px = st ? 32'sd0 : prev_x_r;
    eff_py = st ? 32'sd0 : prev_y_r;
    eff_cx = st ? 32'sd0 : cen_x_r;
    eff_cy = st ? 32'sd0 : cen_y_r;
    vx     = vsel_r ? (VW'(px_r) - VW'(wcx_r)) : w1_r;
    vy     = vsel_r ? (VW'(py_r) - VW'(wcy_r)) : h1_r;
    a2e    = (arc_fwd_r && (a2_r < a1_r)) ? (a2_r + ANG_TWO_PI) : a2_r;
    span   = a2e - a1_r;
    rem_sh = {drem_r, dq_r[AW-1]};
    qbit   = (rem_sh >= {1'b0, steps_r});
    racc   = {1'b0, accr_r} + {1'b0, rs_r};
    rc     = (racc >= {1'b0, steps_r});
    accq_n = accq_r + qs_r + AW'(rc);
    tsum   = macc_r + 56'(prod[45:16]);
    sat_v  = (state_r == S_MUL_XL) ? sat32(44'(wcx_r) + 44'($signed(tsum[55:14])))
                                   : sat32(44'(wcy_r) + 44'($signed(tsum[55:14])));
    dxe    = 33'(em_x_r) - 33'(last_x_r);
    dye    = 33'(em_y_r) - 33'(last_y_r);
    sqsum  = {1'b0, sq_r} + {1'b0, prod[63:0]};
    sq_trial = sqres_r + sqone_r;
    lsum   = {1'b0, len_r} + {1'b0, dist_r};

    // register write, the sequencer reads it only at the span step
    if (cfg_valid) begin
      arc_steps_nxt = cfg_data;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          // outline start wipes the running state before the point is handled
          if (st) begin
            bvalid_nxt  = 1'b0;
            len_nxt     = '0;
            have_em_nxt = 1'b0;
            last_x_nxt  = '0;
            last_y_nxt  = '0;
          end
          px_nxt        = in_point_x;
          py_nxt        = in_point_y;
          item_line_nxt = (in_point_kind == KIND_LINE);
          arc_fwd_nxt   = (eff_pk == KIND_FWD);
          wcx_nxt       = eff_cx;
          wcy_nxt       = eff_cy;
          w1_nxt        = VW'(eff_px) - VW'(eff_cx);
          h1_nxt        = VW'(eff_py) - VW'(eff_cy);
          if (in_point_kind == KIND_LINE) begin
            prev_x_nxt    = in_point_x;
            prev_y_nxt    = in_point_y;
            pend_kind_nxt = KIND_LINE;
          end else begin
            // a closed arc hands its centre on as the next start point
            prev_x_nxt    = (eff_pk != KIND_LINE) ? eff_cx : eff_px;
            prev_y_nxt    = (eff_pk != KIND_LINE) ? eff_cy : eff_py;
            cen_x_nxt     = in_point_x;
            cen_y_nxt     = in_point_y;
            pend_kind_nxt = (in_point_kind == KIND_FWD) ? KIND_FWD : KIND_REV;
          end
          if (eff_pk != KIND_LINE) begin
            vsel_nxt  = 1'b0;
            state_nxt = S_VEC_LD;
          end else if (in_point_kind == KIND_LINE) begin
            em_x_nxt    = in_point_x;
            em_y_nxt    = in_point_y;
            em_last_nxt = 1'b1;
            em_line_nxt = 1'b1;
            state_nxt   = S_EM_BOX;
          end
        end
      end

      S_VEC_LD: begin
        cnt_nxt = '0;
        if (vx == '0 && vy == '0) begin
          // zero vector has angle zero
          if (vsel_r) begin
            a2_nxt    = '0;
            state_nxt = S_SPAN;
          end else begin
            a1_nxt    = '0;
            vsel_nxt  = 1'b1;
          end
        end else begin
          // left half plane: fold over by pi first
          if (vx < 0) begin
            cz_nxt = (vy >= 0) ? ANG_PI : -ANG_PI;
            cx_nxt = -CW'(vx);
            cy_nxt = -CW'(vy);
          end else begin
            cz_nxt = '0;
            cx_nxt = CW'(vx);
            cy_nxt = CW'(vy);
          end
          state_nxt = S_VEC_IT;
        end
      end

      S_VEC_IT: begin
        if (cy_r > 0) begin
          cx_nxt = cx_r + sh_y;
          cy_nxt = cy_r - sh_x;
          cz_nxt = cz_r + atan_v;
        end else begin
          cx_nxt = cx_r - sh_y;
          cy_nxt = cy_r + sh_x;
          cz_nxt = cz_r - atan_v;
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == ITER_CW'(CORDIC_ITERATIONS - 1)) begin
          if (vsel_r) begin
            a2_nxt    = cz_nxt;
            state_nxt = S_SPAN;
          end else begin
            a1_nxt    = cz_nxt;
            vsel_nxt  = 1'b1;
            state_nxt = S_VEC_LD;
          end
        end
      end

      S_SPAN: begin
        span_neg_nxt = span[AW-1];
        dq_nxt       = span[AW-1] ? AW'(-span) : AW'(span);
        drem_nxt     = '0;
        dcnt_nxt     = '0;
        accq_nxt     = '0;
        accr_nxt     = '0;
        k_nxt        = '0;
        if (arc_steps_r < STEPS_MIN) begin
          steps_nxt = STEPS_MIN;
        end else if (arc_steps_r > STEPS_MAX) begin
          steps_nxt = STEPS_MAX;
        end else begin
          steps_nxt = arc_steps_r;
        end
        state_nxt = S_DIV;
      end

      // restoring divide of the span magnitude by the step count
      S_DIV: begin
        drem_nxt = qbit ? SW'(rem_sh - {1'b0, steps_r}) : SW'(rem_sh);
        dq_nxt   = {dq_r[AW-2:0], qbit};
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == DCW'(AW - 1)) begin
          qs_nxt    = dq_nxt;
          rs_nxt    = drem_nxt;
          state_nxt = S_ROT_LD;
        end
      end

      // next angle: |span|*k/steps kept as running quotient and remainder
      S_ROT_LD: begin
        accr_nxt  = rc ? SW'(racc - {1'b0, steps_r}) : SW'(racc);
        accq_nxt  = accq_n;
        k_nxt     = k_r + 1'b1;
        cz_nxt    = span_neg_r ? -$signed(accq_n) : $signed(accq_n);
        cx_nxt    = CW'(w1_r);
        cy_nxt    = CW'(h1_r);
        state_nxt = S_ROT_QT;
      end

      S_ROT_QT: begin
        cnt_nxt = '0;
        if (cz_r > ANG_HALF_PI) begin
          cx_nxt = -cy_r;
          cy_nxt = cx_r;
          cz_nxt = cz_r - ANG_HALF_PI;
        end else if (cz_r < -ANG_HALF_PI) begin
          cx_nxt = cy_r;
          cy_nxt = -cx_r;
          cz_nxt = cz_r + ANG_HALF_PI;
        end else begin
          state_nxt = S_ROT_IT;
        end
      end

      S_ROT_IT: begin
        if (cz_r >= 0) begin
          cx_nxt = cx_r - sh_y;
          cy_nxt = cy_r + sh_x;
          cz_nxt = cz_r - atan_v;
        end else begin
          cx_nxt = cx_r + sh_y;
          cy_nxt = cy_r - sh_x;
          cz_nxt = cz_r + atan_v;
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == ITER_CW'(CORDIC_ITERATIONS - 1)) begin
          state_nxt = S_MUL_XH;
        end
      end

      // gain removal as high and low partial products
      S_MUL_XH: begin
        macc_nxt  = prod[55:0];
        state_nxt = S_MUL_XL;
      end

      S_MUL_XL: begin
        em_x_nxt  = sat_v;
        state_nxt = S_MUL_YH;
      end

      S_MUL_YH: begin
        macc_nxt  = prod[55:0];
        state_nxt = S_MUL_YL;
      end

      S_MUL_YL: begin
        em_y_nxt    = sat_v;
        em_last_nxt = k_last && !item_line_r;
        em_line_nxt = 1'b0;
        state_nxt   = S_EM_BOX;
      end

      S_EM_BOX: begin
        if (!bvalid_r) begin
          bmin_x_nxt = em_x_r;
          bmin_y_nxt = em_y_r;
          bmax_x_nxt = em_x_r;
          bmax_y_nxt = em_y_r;
          bvalid_nxt = 1'b1;
        end else begin
          if (em_x_r < bmin_x_r) bmin_x_nxt = em_x_r;
          if (em_y_r < bmin_y_r) bmin_y_nxt = em_y_r;
          if (em_x_r > bmax_x_r) bmax_x_nxt = em_x_r;
          if (em_y_r > bmax_y_r) bmax_y_nxt = em_y_r;
        end
        ux_nxt = dxe[32] ? 32'(-dxe) : dxe[31:0];
        uy_nxt = dye[32] ? 32'(-dye) : dye[31:0];
        // first point of an outline adds no length
        state_nxt = have_em_r ? S_EM_SQX : S_EM_OUT;
      end

      S_EM_SQX: begin
        sq_nxt    = prod[63:0];
        state_nxt = S_EM_SQY;
      end

      S_EM_SQY: begin
        if (sqsum[64]) begin
          dist_nxt  = 32'hFFFFFFFF;
          state_nxt = S_EM_ACC;
        end else begin
          sqv_nxt   = sqsum[63:0];
          sqres_nxt = '0;
          sqone_nxt = 64'h4000000000000000;
          state_nxt = S_EM_SQRT;
        end
      end

      // bit-pair square root, one result bit a cycle
      S_EM_SQRT: begin
        if (sqv_r >= sq_trial) begin
          sqv_nxt   = sqv_r - sq_trial;
          sqres_nxt = (sqres_r >> 1) + sqone_r;
        end else begin
          sqres_nxt = sqres_r >> 1;
        end
        sqone_nxt = sqone_r >> 2;
        if (sqone_r[0]) begin
          dist_nxt  = sqres_nxt[31:0];
          state_nxt = S_EM_ACC;
        end
      end

      S_EM_ACC: begin
        len_nxt   = lsum[32] ? 32'hFFFFFFFF : lsum[31:0];
        state_nxt = S_EM_OUT;
      end

      S_EM_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          ox_nxt        = em_x_r;
          oy_nxt        = em_y_r;
          obnx_nxt      = bmin_x_r;
          obny_nxt      = bmin_y_r;
          obxx_nxt      = bmax_x_r;
          obxy_nxt      = bmax_y_r;
          olen_nxt      = len_r;
          olast_nxt     = em_last_r;
          last_x_nxt    = em_x_r;
          last_y_nxt    = em_y_r;
          have_em_nxt   = 1'b1;
          if (em_line_r) begin
            state_nxt = S_IDLE;
          end else if (k_last) begin
            // arc done: a line vertex still follows as its own point
            if (item_line_r) begin
              em_x_nxt    = px_r;
              em_y_nxt    = py_r;
              em_last_nxt = 1'b1;
              em_line_nxt = 1'b1;
              state_nxt   = S_EM_BOX;
            end else begin
              state_nxt = S_IDLE;
            end
          end else begin
            state_nxt = S_ROT_LD;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      arc_steps_r <= STEPS_RESET;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      cen_x_r     <= '0;
      cen_y_r     <= '0;
      pend_kind_r <= KIND_LINE;
      last_x_r    <= '0;
      last_y_r    <= '0;
      have_em_r   <= 1'b0;
      bmin_x_r    <= '0;
      bmin_y_r    <= '0;
      bmax_x_r    <= '0;
      bmax_y_r    <= '0;
      bvalid_r    <= 1'b0;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      arc_steps_r <= arc_steps_nxt;
      prev_x_r    <= prev_x_nxt;
      prev_y_r    <= prev_y_nxt;
      cen_x_r     <= cen_x_nxt;
      cen_y_r     <= cen_y_nxt;
      pend_kind_r <= pend_kind_nxt;
      last_x_r    <= last_x_nxt;
      last_y_r    <= last_y_nxt;
      have_em_r   <= have_em_nxt;
      bmin_x_r    <= bmin_x_nxt;
      bmin_y_r    <= bmin_y_nxt;
      bmax_x_r    <= bmax_x_nxt;
      bmax_y_r    <= bmax_y_nxt;
      bvalid_r    <= bvalid_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    px_r        <= px_nxt;
    py_r        <= py_nxt;
    item_line_r <= item_line_nxt;
    arc_fwd_r   <= arc_fwd_nxt;
    wcx_r       <= wcx_nxt;
    wcy_r       <= wcy_nxt;
    w1_r        <= w1_nxt;
    h1_r        <= h1_nxt;
    steps_r     <= steps_nxt;
    k_r         <= k_nxt;
    cx_r        <= cx_nxt;
    cy_r        <= cy_nxt;
    cz_r        <= cz_nxt;
    cnt_r       <= cnt_nxt;
    vsel_r      <= vsel_nxt;
    a1_r        <= a1_nxt;
    a2_r        <= a2_nxt;
    dq_r        <= dq_nxt;
    drem_r      <= drem_nxt;
    dcnt_r      <= dcnt_nxt;
    span_neg_r  <= span_neg_nxt;
    qs_r        <= qs_nxt;
    rs_r        <= rs_nxt;
    accq_r      <= accq_nxt;
    accr_r      <= accr_nxt;
    macc_r      <= macc_nxt;
    em_x_r      <= em_x_nxt;
    em_y_r      <= em_y_nxt;
    em_last_r   <= em_last_nxt;
    em_line_r   <= em_line_nxt;
    ux_r        <= ux_nxt;
    uy_r        <= uy_nxt;
    sq_r        <= sq_nxt;
    sqv_r       <= sqv_nxt;
    sqres_r     <= sqres_nxt;
    sqone_r     <= sqone_nxt;
    dist_r      <= dist_nxt;
    ox_r        <= ox_nxt;
    oy_r        <= oy_nxt;
    obnx_r      <= obnx_nxt;
    obny_r      <= obny_nxt;
    obxx_r      <= obxx_nxt;
    obxy_r      <= obxy_nxt;
    olen_r      <= olen_nxt;
    olast_r     <= olast_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_x           = ox_r;
  assign out_y           = oy_r;
  assign out_box_min_x   = obnx_r;
  assign out_box_min_y   = obny_r;
  assign out_box_max_x   = obxx_r;
  assign out_box_max_y   = obxy_r;
  assign out_path_length = olen_r;
  assign out_run_last    = olast_r;

endmodule

// ----- hdl/aot_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aot_checker
// Port-level checks for the arc outline tessellator, bound to the top level.
// ----------------------------------------------------------------------------
module aot_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_x,
  input logic signed [31:0] out_y,
  input logic signed [31:0] out_box_min_x,
  input logic signed [31:0] out_box_min_y,
  input logic signed [31:0] out_box_max_x,
  input logic signed [31:0] out_box_max_y,
  input logic               out_run_last
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(out_y)
      && $stable(out_run_last))
    else $error("stalled result changed");

  // emitted point lies inside the reported box
  a_box_x: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_box_min_x <= out_x && out_x <= out_box_max_x)
    else $error("x outside bounding box");

  a_box_y: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_box_min_y <= out_y && out_y <= out_box_max_y)
    else $error("y outside bounding box");

  // more results of the item still to come, so no new transfer is taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_run_last |-> in_stall)
    else $error("input taken before last result of an item");

endmodule

bind arc_outline_tessellator_unit aot_checker u_aot_checker (.*);
